// ===== design/bfa_pkg.sv =====
// Shared widths, operation codes and channel word types for the bitmap frame allocator.
package bfa_pkg;

   localparam int OP_W       = 2;
   localparam int PAGE_IDX_W = 12;
   localparam int COUNT_W    = 13;
   localparam int ADDR_W     = 24;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;
   localparam logic [OP_W-1:0] OP_TEST    = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [PAGE_IDX_W-1:0] page_index;
   } bfa_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] frame_address;
      logic              ok;
      logic              was_used;
   } bfa_rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] page_count;
   } bfa_csr_type;

endpackage

// ===== design/bfa_chan_if.sv =====
// Valid/ready channel carrying one word of a given type.
interface bfa_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/bitmap_frame_allocator_top.sv =====
// Bitmap page frame allocator, first fit, over a synchronous bitmap memory with one read and one write port.
//
//  channel | dir | payload                              | accepted when
//  req_ch  | in  | op, page_index                       | valid & ready
//  rsp_ch  | out | frame_address, ok, was_used          | valid & ready
//  csr_ch  | in  | page_count                           | valid & ready (ready always high)
//
//  After reset the bitmap is filled with ones, one word a cycle; req is not ready until the fill is done.
//  Free, reserve, test: word index, bit offset, read-modify-write (test only reads), result, in that order.
//  Alloc: one bitmap word checked per cycle until a free page is found or the page limit is reached.
//  A result waits in the output register; the block is ready again once it is loaded there.
module bitmap_frame_allocator_top #(
   parameter int NUM_PAGES  = 4096,
   parameter int WORD_BITS  = 64,
   parameter int PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   bfa_chan_if.sink    req_ch,
   bfa_chan_if.source  rsp_ch,
   bfa_chan_if.sink    csr_ch
);

   import bfa_pkg::*;

   localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int BASE_W    = COUNT_W + 1;
   localparam int CAP_I     = (NUM_PAGES < (1 << COUNT_W) - 1) ? NUM_PAGES : (1 << COUNT_W) - 1;
   localparam int DIV_SH    = 20;
   localparam int RECIP_W   = DIV_SH - 1;
   localparam int RECIP_I   = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int QUOT_W    = PAGE_IDX_W - 3;
   localparam int PROD_W    = PAGE_IDX_W + RECIP_W;
   localparam int PB_W      = $clog2(PAGE_BYTES + 1);

   localparam logic [COUNT_W-1:0] LIM_CAP   = COUNT_W'(CAP_I);
   localparam logic [BASE_W-1:0]  WORD_STEP = BASE_W'(WORD_BITS);
   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);
   localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_I);
   localparam logic [PB_W-1:0]    PB        = PB_W'(PAGE_BYTES);

   typedef enum logic [6:0] {
      ST_FILL = 7'b0000001,
      ST_IDLE = 7'b0000010,
      ST_DIV  = 7'b0000100,
      ST_REM  = 7'b0001000,
      ST_MOD  = 7'b0010000,
      ST_SCAN = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [PAGE_IDX_W-1:0]  idx_ff, idx_in;
   logic [QUOT_W-1:0]      q_ff, q_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   logic [WADDR_W-1:0]     scan_addr_ff, scan_addr_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [WADDR_W-1:0]     fill_addr_ff, fill_addr_in;
   logic [COUNT_W-1:0]     res_page_ff, res_page_in;
   logic                   res_ok_ff, res_ok_in;
   logic                   res_prior_ff, res_prior_in;
   logic [COUNT_W-1:0]     page_count_ff;
   bfa_rsp_type            rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]   rd_data_ff;

   logic [WORD_BITS-1:0]   map_mem [MAP_WORDS];

   logic                   we_c;
   logic [WADDR_W-1:0]     wa_c;
   logic [WADDR_W-1:0]     ra_c;
   logic [WORD_BITS-1:0]   wd_c;

   logic [COUNT_W-1:0]     lim_c;
   logic [BASE_W-1:0]      lim_ext;
   logic [BASE_W-1:0]      avail_c;
   logic                   found_c;
   logic [BIT_W-1:0]       first_bit_c;
   logic [PROD_W-1:0]      div_prod;
   logic [COUNT_W+PB_W-1:0] addr_prod;
   logic                   req_fire;
   logic                   rsp_load;

   assign lim_c    = (page_count_ff > LIM_CAP) ? LIM_CAP : page_count_ff;
   assign lim_ext  = {1'b0, lim_c};
   assign avail_c  = lim_ext - base_ff;
   assign div_prod = PROD_W'(idx_ff) * PROD_W'(RECIP);
   assign addr_prod = (COUNT_W + PB_W)'(res_page_ff) * (COUNT_W + PB_W)'(PB);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_load     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

   bfa_free_find #(
      .WORD_BITS (WORD_BITS),
      .BIT_W     (BIT_W),
      .AVAIL_W   (BASE_W)
   ) u_find (
      .word_used (rd_data_ff),
      .avail     (avail_c),
      .found     (found_c),
      .first_bit (first_bit_c)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      q_in         = q_ff;
      bit_in       = bit_ff;
      scan_addr_in = scan_addr_ff;
      base_in      = base_ff;
      fill_addr_in = fill_addr_ff;
      res_page_in  = res_page_ff;
      res_ok_in    = res_ok_ff;
      res_prior_in = res_prior_ff;
      we_c         = 1'b0;
      wa_c         = scan_addr_ff;
      wd_c         = rd_data_ff;
      ra_c         = scan_addr_ff;

      unique case (state_ff)
         ST_FILL: begin
            we_c = 1'b1;
            wa_c = fill_addr_ff;
            wd_c = '1;
            if (fill_addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            ra_c = '0;
            if (req_fire) begin
               op_in  = req_ch.data.op;
               idx_in = req_ch.data.page_index;
               if (req_ch.data.op == OP_ALLOC) begin
                  if (lim_c == '0) begin
                     res_ok_in    = 1'b0;
                     res_prior_in = 1'b1;
                     res_page_in  = '0;
                     state_in     = ST_EMIT;
                  end else begin
                     scan_addr_in = '0;
                     base_in      = '0;
                     state_in     = ST_SCAN;
                  end
               end else if (COUNT_W'(req_ch.data.page_index) < lim_c) begin
                  state_in = ST_DIV;
               end else begin
                  res_ok_in    = 1'b0;
                  res_prior_in = 1'b0;
                  res_page_in  = '0;
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_DIV: begin
            q_in     = div_prod[DIV_SH +: QUOT_W];
            state_in = ST_REM;
         end
         ST_REM: begin
            bit_in   = BIT_W'(idx_ff - PAGE_IDX_W'(q_ff * WORD_BITS));
            ra_c     = WADDR_W'(q_ff);
            state_in = ST_MOD;
         end
         ST_MOD: begin
            wa_c         = WADDR_W'(q_ff);
            res_prior_in = rd_data_ff[bit_ff];
            res_ok_in    = 1'b1;
            res_page_in  = COUNT_W'(idx_ff);
            case (op_ff)
               OP_FREE: begin
                  we_c = 1'b1;
                  wd_c = rd_data_ff & ~(WORD_BITS'(1) << bit_ff);
               end
               OP_RESERVE: begin
                  we_c = 1'b1;
                  wd_c = rd_data_ff | (WORD_BITS'(1) << bit_ff);
               end
               default: begin
                  we_c = 1'b0;
               end
            endcase
            state_in = ST_EMIT;
         end
         ST_SCAN: begin
            ra_c = (scan_addr_ff == LAST_WORD) ? scan_addr_ff : scan_addr_ff + 1'b1;
            if (found_c) begin
               we_c         = 1'b1;
               wa_c         = scan_addr_ff;
               wd_c         = rd_data_ff | (WORD_BITS'(1) << first_bit_c);
               res_page_in  = COUNT_W'(base_ff + BASE_W'(first_bit_c));
               res_ok_in    = 1'b1;
               res_prior_in = 1'b0;
               state_in     = ST_EMIT;
            end else if (base_ff + WORD_STEP >= lim_ext) begin
               res_page_in  = '0;
               res_ok_in    = 1'b0;
               res_prior_in = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
               base_in      = base_ff + WORD_STEP;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.frame_address = addr_prod[ADDR_W-1:0];
         rsp_in.ok            = res_ok_ff;
         rsp_in.was_used      = res_prior_ff;
         rsp_valid_in         = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we_c) begin
         map_mem[wa_c] <= wd_c;
      end
      rd_data_ff <= map_mem[ra_c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         fill_addr_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         page_count_ff <= COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         fill_addr_ff  <= fill_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            page_count_ff <= csr_ch.data.page_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      q_ff         <= q_in;
      bit_ff       <= bit_in;
      scan_addr_ff <= scan_addr_in;
      base_ff      <= base_in;
      res_page_ff  <= res_page_in;
      res_ok_ff    <= res_ok_in;
      res_prior_ff <= res_prior_in;
      rsp_ff       <= rsp_in;
   end

   a_scan_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (base_ff < lim_ext))
      else $error("alloc scan went past the page limit");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.ok) |-> (rsp_ff.frame_address == '0))
      else $error("failed word carries a non-zero frame address");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result word raised outside the emit state");

endmodule

// ===== design/bfa_free_find.sv =====
// Lowest free page search within one bitmap word, limited to the pages still below the limit.
module bfa_free_find #(
   parameter int WORD_BITS = 64,
   parameter int BIT_W     = 6,
   parameter int AVAIL_W   = 14
) (
   input  logic [WORD_BITS-1:0] word_used,
   input  logic [AVAIL_W-1:0]   avail,
   output logic                 found,
   output logic [BIT_W-1:0]     first_bit
);

   logic [WORD_BITS-1:0] free_v;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         free_v[b] = !word_used[b] && (AVAIL_W'(b) < avail);
      end
   end

   always_comb begin
      first_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_v[b]) begin
            first_bit = BIT_W'(b);
         end
      end
   end

   assign found = |free_v;

endmodule
